[hdl/mpam_pkg.sv]
// Shared types and constants of the multi-pattern automaton matcher.
// No dependencies; imported by every module of the block but mpam_ram.
package mpam_pkg;

  localparam int NODES_DEF    = 1024;
  localparam int ALPHABET_DEF = 32;
  localparam int SYM_W        = 5;
  localparam int IDX_W        = 10;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_SCAN  = 2'd2;

  typedef struct packed {
    logic [1:0]       action;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } in_word_t;

  typedef struct packed {
    logic             matched;
    logic [IDX_W-1:0] state_index;
    logic             status;
  } out_word_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_CLR, OP_A_RD, OP_A_EV, OP_W_RD, OP_W_EV, OP_S_TRD, OP_S_TEV,
    OP_B_INIT, OP_B_POP, OP_B_V, OP_B_FV, OP_B_FVW, OP_B_GRD, OP_B_GEV, OP_B_FIN,
    OP_B_TM, OP_B_NEXT, OP_ZERO, OP_OUT
  } op_e;

  typedef struct packed {
    logic [1:0] in_action;
    logic       in_sym_ok;
    logic       clr_last;
    logic       goto_zero;
    logic       node_zero;
    logic       steps_end;
    logic       q_empty;
    logic       v_zero;
    logic       c_last;
    logic       out_free;
  } dp_status_t;

endpackage

[hdl/mpam_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mpam_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [$clog2(D)-1:0] waddr_i,
  input  logic [W-1:0]         wdata_i,
  input  logic [$clog2(D)-1:0] raddr_i,
  output logic [W-1:0]         rdata_o
);
  logic [W-1:0] mem_q [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[hdl/mpam_datapath.sv]
// Datapath: trie, failure-link, terminal and queue memories, cursors and result register.
// Depends on mpam_pkg and mpam_ram; driven by op codes from mpam_ctrl.
module mpam_datapath import mpam_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  op_e        op_i,
  input  in_word_t   in_data_i,
  input  logic       out_ready_i,
  output logic       out_valid_o,
  output out_word_t  out_data_o,
  output dp_status_t status_o
);
  localparam int NW = $clog2(NODES);
  localparam int SW = $clog2(ALPHABET);
  localparam int GA = NW + SW;
  localparam logic [NW:0]   NODES_L   = (NW+1)'(NODES);
  localparam logic [8:0]    ALPHA_L   = 9'(ALPHABET);
  localparam logic [SW-1:0] C_LAST    = SW'(ALPHABET - 1);
  localparam logic [NW-1:0] STEP_LAST = NW'(NODES - 1);

  logic          g_we, fl_we, tm_we, q_we;
  logic [GA-1:0] g_waddr, g_raddr;
  logic [NW-1:0] g_wdata, g_rdata;
  logic [NW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;
  logic [NW-1:0] tm_waddr, tm_raddr;
  logic          tm_wdata, tm_rdata;
  logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;

  logic [SW-1:0] sym_q, sym_d, wsym_q, wsym_d, c_q, c_d;
  logic          sym_ok_q, sym_ok_d, last_q, last_d;
  logic [NW-1:0] cursor_q, cursor_d, scan_q, scan_d, w_q, w_d, steps_q, steps_d;
  logic [NW-1:0] f_q, f_d, v_q, v_d, fv_q, fv_d, u_q, u_d;
  logic [NW:0]   count_q, count_d, head_q, head_d, tail_q, tail_d;
  logic [GA-1:0] clr_q, clr_d;
  out_word_t     res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  logic [8:0]    in_sym_ext;
  logic [SW-1:0] in_sym_idx;
  logic          a_hit, a_room, a_full, a_new;
  logic [NW-1:0] a_cur;

  assign in_sym_ext = 9'(in_data_i.symbol);
  assign in_sym_idx = in_sym_ext[SW-1:0];

  assign a_hit  = g_rdata != '0;
  assign a_room = count_q < NODES_L;
  assign a_full = sym_ok_q && !a_hit && !a_room;
  assign a_new  = sym_ok_q && !a_hit && a_room;
  always_comb begin
    if (!sym_ok_q || a_full) a_cur = cursor_q;
    else if (a_hit)          a_cur = g_rdata;
    else                     a_cur = count_q[NW-1:0];
  end

  always_comb begin
    sym_d = sym_q; wsym_d = wsym_q; c_d = c_q; sym_ok_d = sym_ok_q; last_d = last_q;
    cursor_d = cursor_q; scan_d = scan_q; w_d = w_q; steps_d = steps_q;
    f_d = f_q; v_d = v_q; fv_d = fv_q; u_d = u_q;
    count_d = count_q; head_d = head_q; tail_d = tail_q; clr_d = clr_q;
    res_d = res_q; out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    g_we = 1'b0;  g_waddr = {cursor_q, sym_q}; g_wdata = count_q[NW-1:0];
    g_raddr = {w_q, wsym_q};
    fl_we = 1'b0; fl_waddr = u_q; fl_wdata = f_q; fl_raddr = w_q;
    tm_we = 1'b0; tm_waddr = u_q; tm_wdata = 1'b1; tm_raddr = f_q;
    q_we = 1'b0;  q_waddr = tail_q[NW-1:0]; q_wdata = u_q; q_raddr = head_q[NW-1:0];
    unique case (op_i)
      OP_CLR: begin
        g_we = 1'b1; g_waddr = clr_q; g_wdata = '0;
        tm_we = 1'b1; tm_waddr = clr_q[GA-1:SW]; tm_wdata = 1'b0;
        clr_d = clr_q + 1'b1;
      end
      OP_LOAD: begin
        sym_d = in_sym_idx; sym_ok_d = in_sym_ext < ALPHA_L; last_d = in_data_i.last;
        w_d = scan_q; wsym_d = in_sym_idx; steps_d = '0; f_d = '0;
      end
      OP_A_RD: g_raddr = {cursor_q, sym_q};
      OP_A_EV: begin
        if (a_new) begin
          g_we = 1'b1;
          count_d = count_q + 1'b1;
        end
        if (last_q && sym_ok_q && !a_full) begin
          tm_we = 1'b1; tm_waddr = a_cur;
        end
        cursor_d = last_q ? '0 : a_cur;
        res_d = '{matched: 1'b0, state_index: IDX_W'(a_cur), status: a_full};
      end
      OP_W_RD: begin
        g_raddr = {w_q, wsym_q}; fl_raddr = w_q;
      end
      OP_W_EV: begin
        f_d = g_rdata; w_d = fl_rdata; steps_d = steps_q + 1'b1;
      end
      OP_S_TRD: scan_d = f_q;
      OP_S_TEV: res_d = '{matched: tm_rdata, state_index: IDX_W'(f_q), status: 1'b0};
      OP_B_INIT: begin
        q_we = 1'b1; q_waddr = '0; q_wdata = '0;
        head_d = '0; tail_d = (NW+1)'(1);
      end
      OP_B_POP: if (head_q == tail_q) scan_d = '0;
      OP_B_V: begin
        v_d = q_rdata; head_d = head_q + 1'b1;
      end
      OP_B_FV: fl_raddr = v_q;
      OP_B_FVW: begin
        fv_d = fl_rdata; c_d = '0;
      end
      OP_B_GRD: g_raddr = {v_q, c_q};
      OP_B_GEV: begin
        u_d = g_rdata; f_d = '0; w_d = fv_q; wsym_d = c_q; steps_d = '0;
      end
      OP_B_FIN: begin
        fl_we = 1'b1;
        if (tail_q < NODES_L) begin
          q_we = 1'b1; tail_d = tail_q + 1'b1;
        end
      end
      OP_B_TM: tm_we = tm_rdata;
      OP_B_NEXT: c_d = c_q + 1'b1;
      OP_ZERO: res_d = '0;
      OP_OUT: begin
        out_valid_d = 1'b1; out_d = res_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0; scan_q <= '0; count_q <= (NW+1)'(1);
      clr_q <= '0; out_valid_q <= 1'b0; head_q <= '0; tail_q <= '0;
    end else begin
      cursor_q <= cursor_d; scan_q <= scan_d; count_q <= count_d;
      clr_q <= clr_d; out_valid_q <= out_valid_d; head_q <= head_d; tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q <= sym_d; wsym_q <= wsym_d; c_q <= c_d; sym_ok_q <= sym_ok_d; last_q <= last_d;
    w_q <= w_d; steps_q <= steps_d; f_q <= f_d; v_q <= v_d; fv_q <= fv_d; u_q <= u_d;
    res_q <= res_d; out_q <= out_d;
  end

  mpam_ram #(.W(NW), .D(1 << GA)) u_goto (
    .clk_i, .we_i(g_we), .waddr_i(g_waddr), .wdata_i(g_wdata),
    .raddr_i(g_raddr), .rdata_o(g_rdata)
  );
  mpam_ram #(.W(NW), .D(1 << NW)) u_fail (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );
  mpam_ram #(.W(1), .D(1 << NW)) u_term (
    .clk_i, .we_i(tm_we), .waddr_i(tm_waddr), .wdata_i(tm_wdata),
    .raddr_i(tm_raddr), .rdata_o(tm_rdata)
  );
  mpam_ram #(.W(NW), .D(1 << NW)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  assign status_o = '{
    in_action: in_data_i.action,
    in_sym_ok: in_sym_ext < ALPHA_L,
    clr_last:  clr_q == '1,
    goto_zero: g_rdata == '0,
    node_zero: w_q == '0,
    steps_end: steps_q == STEP_LAST,
    q_empty:   head_q == tail_q,
    v_zero:    v_q == '0,
    c_last:    c_q == C_LAST,
    out_free:  !out_valid_q || out_ready_i
  };
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
endmodule

[hdl/mpam_ctrl.sv]
// Controller state machine: sequences clearing, insert, scan walk and breadth-first build.
// Depends on mpam_pkg; issues op codes to mpam_datapath.
module mpam_ctrl import mpam_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output op_e        op_o
);
  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_A_RD = 5'd2, S_A_EV = 5'd3,
    S_W_RD = 5'd4, S_W_EV = 5'd5, S_S_TRD = 5'd6, S_S_TEV = 5'd7, S_B_INIT = 5'd8,
    S_B_POP = 5'd9, S_B_V = 5'd10, S_B_FV = 5'd11, S_B_FVW = 5'd12, S_B_GRD = 5'd13,
    S_B_GEV = 5'd14, S_B_FIN = 5'd15, S_B_TM = 5'd16, S_B_NEXT = 5'd17, S_ZERO = 5'd18,
    S_OUT = 5'd19;

  logic [4:0] state_q, state_d;
  logic       ret_q, ret_d;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (status_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: if (in_valid_i) begin
        op_o = OP_LOAD;
        unique case (status_i.in_action)
          ACT_ADD:   state_d = S_A_RD;
          ACT_BUILD: state_d = S_B_INIT;
          ACT_SCAN: begin
            ret_d   = 1'b0;
            state_d = status_i.in_sym_ok ? S_W_RD : S_S_TRD;
          end
          default:   state_d = S_ZERO;
        endcase
      end
      S_A_RD: begin op_o = OP_A_RD; state_d = S_A_EV; end
      S_A_EV: begin op_o = OP_A_EV; state_d = S_OUT; end
      S_W_RD: begin op_o = OP_W_RD; state_d = S_W_EV; end
      S_W_EV: begin
        op_o = OP_W_EV;
        if (!status_i.goto_zero || status_i.node_zero || status_i.steps_end) begin
          state_d = ret_q ? S_B_FIN : S_S_TRD;
        end else begin
          state_d = S_W_RD;
        end
      end
      S_S_TRD: begin op_o = OP_S_TRD; state_d = S_S_TEV; end
      S_S_TEV: begin op_o = OP_S_TEV; state_d = S_OUT; end
      S_B_INIT: begin op_o = OP_B_INIT; state_d = S_B_POP; end
      S_B_POP: begin
        op_o = OP_B_POP;
        state_d = status_i.q_empty ? S_ZERO : S_B_V;
      end
      S_B_V:   begin op_o = OP_B_V;   state_d = S_B_FV;  end
      S_B_FV:  begin op_o = OP_B_FV;  state_d = S_B_FVW; end
      S_B_FVW: begin op_o = OP_B_FVW; state_d = S_B_GRD; end
      S_B_GRD: begin op_o = OP_B_GRD; state_d = S_B_GEV; end
      S_B_GEV: begin
        op_o = OP_B_GEV;
        if (status_i.goto_zero) state_d = S_B_NEXT;
        else if (status_i.v_zero) state_d = S_B_FIN;
        else begin
          ret_d   = 1'b1;
          state_d = S_W_RD;
        end
      end
      S_B_FIN: begin op_o = OP_B_FIN; state_d = S_B_TM; end
      S_B_TM:  begin op_o = OP_B_TM;  state_d = S_B_NEXT; end
      S_B_NEXT: begin
        op_o = OP_B_NEXT;
        state_d = status_i.c_last ? S_B_POP : S_B_GRD;
      end
      S_ZERO: begin op_o = OP_ZERO; state_d = S_OUT; end
      S_OUT: if (status_i.out_free) begin
        op_o    = OP_OUT;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      ret_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;
endmodule

[hdl/multi_pattern_automaton_matcher.sv]
// Top level of the Aho-Corasick dictionary matcher.
// Depends on mpam_pkg, mpam_ctrl, mpam_datapath (and mpam_ram below it).

// One word is in work at a time; its result goes to an output register, so the next word
// is taken while a result waits. After reset a clearing pass over all 2**(clog2(NODES) +
// clog2(ALPHABET)) trie slots (32768 at defaults) zeroes the trie and terminal memories;
// no word is accepted meanwhile. An add steps through accept, trie read, update, output.
// A scan follows the goto lookups along the failure chain, each one registered read of the
// trie memory, then reads the terminal flag and outputs. A build walks every node in
// breadth-first order, reading each (node, symbol) slot and, for each child, following the
// failure chain, all bound by the single trie read port.
module multi_pattern_automaton_matcher import mpam_pkg::*; #(
  parameter int NODES    = NODES_DEF,
  parameter int ALPHABET = ALPHABET_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);
  op_e        op;
  dp_status_t status;

  mpam_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .status_i(status), .op_o(op)
  );

  mpam_datapath #(.NODES(NODES), .ALPHABET(ALPHABET)) u_dp (
    .clk_i, .rst_ni, .op_i(op), .in_data_i, .out_ready_i, .out_valid_o, .out_data_o,
    .status_o(status)
  );
endmodule

[sim/tb_multi_pattern_automaton_matcher.sv]
// Testbench of multi_pattern_automaton_matcher: directed dictionaries, random rounds and
// an overflow run, checked word by word against a predictor of the trie automaton.
// Depends on mpam_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module tb_multi_pattern_automaton_matcher;
  import mpam_pkg::*;

  localparam int NODES     = NODES_DEF;
  localparam int ALPHABET  = ALPHABET_DEF;
  localparam int LIMIT     = 4_000_000;
  localparam int HOLD_LEN  = 400;
  localparam logic [1:0] ACT_NONE = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_word_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_word_t out_data_o;

  multi_pattern_automaton_matcher i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // predicted automaton
  logic [IDX_W-1:0] trie_next [NODES*ALPHABET];
  logic [IDX_W-1:0] fail_of [NODES];
  bit               term_of [NODES];
  int               nodes_used;
  int               cursor_at;
  int               scan_at;
  bit               trie_dirty;

  out_word_t expected_words[$];
  int        errors;
  int        cycles;
  bit        quiet;
  bit        hold_go;
  int        held;

  function automatic int follow_links(int node, int sym);
    int t;
    for (int steps = 0; steps < NODES; steps++) begin
      t = int'(trie_next[node*ALPHABET + sym]);
      if (t != 0) return t;
      if (node == 0) return 0;
      node = int'(fail_of[node]);
    end
    return 0;
  endfunction

  function automatic void build_fail_links();
    int bfs[NODES];
    int head;
    int tail;
    int v;
    int u;
    int f;
    head = 0;
    tail = 1;
    bfs[0] = 0;
    while (head < tail) begin
      v = bfs[head];
      head++;
      for (int c = 0; c < ALPHABET; c++) begin
        u = int'(trie_next[v*ALPHABET + c]);
        if (u != 0) begin
          f = (v == 0) ? 0 : follow_links(int'(fail_of[v]), c);
          fail_of[u] = IDX_W'(f);
          term_of[u] = term_of[u] | term_of[f];
          if (tail < NODES) begin
            bfs[tail] = u;
            tail++;
          end
        end
      end
    end
    scan_at = 0;
    trie_dirty = 0;
  endfunction

  function automatic out_word_t predict_word(in_word_t w);
    out_word_t r;
    int slot;
    r = '0;
    case (w.action)
      ACT_ADD: begin
        slot = cursor_at*ALPHABET + w.symbol;
        if (trie_next[slot] == 0) begin
          if (nodes_used < NODES) begin
            trie_next[slot] = IDX_W'(nodes_used);
            nodes_used++;
            trie_dirty = 1;
          end else begin
            r.status = 1'b1;
          end
        end
        if (!r.status) cursor_at = int'(trie_next[slot]);
        r.state_index = IDX_W'(cursor_at);
        if (w.last) begin
          if (!r.status) begin
            if (!term_of[cursor_at]) trie_dirty = 1;
            term_of[cursor_at] = 1;
          end
          cursor_at = 0;
        end
      end
      ACT_BUILD: build_fail_links();
      ACT_SCAN: begin
        scan_at = follow_links(scan_at, w.symbol);
        r.state_index = IDX_W'(scan_at);
        r.matched = term_of[scan_at];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic int pick_gap();
    int p;
    if (quiet) return 0;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic send_word(in_word_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    expected_words = {expected_words, predict_word(w)};
  endtask

  task automatic send_op(logic [1:0] act, int sym, bit last);
    in_word_t w;
    w.action = act;
    w.symbol = sym[SYM_W-1:0];
    w.last   = last;
    send_word(w);
  endtask

  task automatic add_text(int syms[$]);
    foreach (syms[i]) send_op(ACT_ADD, syms[i], i == syms.size() - 1);
  endtask

  task automatic test_directed_dictionary();
    int text[9];
    text = '{18, 7, 4, 17, 18, 8, 18, 31, 0};
    // h=7 e=4 s=18 i=8 r=17 -> he, she, his, hers
    quiet = 1;
    send_op(ACT_SCAN, 31, 0);
    send_op(ACT_SCAN, 0, 1);
    send_op(ACT_NONE, 31, 1);
    add_text('{7, 4});
    add_text('{18, 7, 4});
    add_text('{7, 8, 18});
    add_text('{7, 4, 17, 18});
    send_op(ACT_BUILD, 0, 0);
    quiet = 0;
    foreach (text[i]) send_op(ACT_SCAN, text[i], 0);
    send_op(ACT_ADD, 7, 0);
    send_op(ACT_ADD, 7, 1);
    send_op(ACT_BUILD, 31, 1);
    send_op(ACT_SCAN, 7, 0);
    send_op(ACT_NONE, 0, 0);
  endtask

  task automatic test_random_rounds();
    int nwords;
    int len;
    int sym;
    for (int round = 0; round < 6; round++) begin
      if (round == 2) hold_go = 1;
      nwords = $urandom_range(2);
      for (int k = 0; k < nwords; k++) begin
        len = $urandom_range(5, 1);
        for (int j = 0; j < len; j++) begin
          sym = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(3);
          send_op(ACT_ADD, sym, j == len - 1);
        end
      end
      if ($urandom_range(5) == 0) send_op(ACT_ADD, $urandom_range(3), 0);
      if ($urandom_range(7) == 0) send_op(ACT_NONE, $urandom_range(31), $urandom_range(1));
      if (trie_dirty || $urandom_range(3) == 0) send_op(ACT_BUILD, $urandom_range(31), 0);
      for (int j = 0; j < 18; j++) begin
        sym = ($urandom_range(7) == 0) ? $urandom_range(31) : $urandom_range(3);
        send_op(ACT_SCAN, sym, $urandom_range(1));
      end
    end
  endtask

  task automatic test_table_overflow();
    int len;
    while (nodes_used < NODES) begin
      len = $urandom_range(16, 8);
      for (int j = 0; j < len; j++) send_op(ACT_ADD, $urandom_range(31), j == len - 1);
    end
    for (int j = 0; j < 6; j++) send_op(ACT_ADD, $urandom_range(31), j == 2 || j == 5);
    send_op(ACT_BUILD, 0, 0);
    for (int j = 0; j < 40; j++) send_op(ACT_SCAN, $urandom_range(31), 0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    if (hold_go && held < HOLD_LEN) begin
      out_ready_i <= 1'b0;
      held <= held + 1;
    end else if (quiet) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) < 70) ||
                     ($urandom_range(99) < 3 ? 1'b0 : $urandom_range(1));
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word %h", out_data_o);
        errors++;
      end else begin
        e = expected_words.pop_front();
        if (out_data_o.matched !== e.matched) begin
          $error("matched: expected %0d, got %0d", e.matched, out_data_o.matched);
          errors++;
        end
        if (out_data_o.state_index !== e.state_index) begin
          $error("state_index: expected %0d, got %0d", e.state_index,
                 out_data_o.state_index);
          errors++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_multi_pattern_automaton_matcher failed");
      $finish;
    end
  end

  initial begin
    int tail_wait;
    for (int i = 0; i < NODES*ALPHABET; i++) trie_next[i] = '0;
    for (int i = 0; i < NODES; i++) begin
      fail_of[i] = '0;
      term_of[i] = 0;
    end
    nodes_used = 1;
    cursor_at  = 0;
    scan_at    = 0;
    trie_dirty = 0;
    errors     = 0;
    cycles     = 0;
    quiet      = 0;
    hold_go    = 0;
    held       = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_dictionary();
    test_random_rounds();
    test_table_overflow();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    tail_wait = 0;
    while (expected_words.size() != 0) @(posedge clk_i);
    while (tail_wait < 200) begin
      @(posedge clk_i);
      tail_wait++;
    end
    if (errors == 0 && expected_words.size() == 0) begin
      $display("tb_multi_pattern_automaton_matcher passed");
    end else begin
      $display("tb_multi_pattern_automaton_matcher failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/mpam_pkg.sv
hdl/mpam_ram.sv
hdl/mpam_datapath.sv
hdl/mpam_ctrl.sv
hdl/multi_pattern_automaton_matcher.sv
sim/tb_multi_pattern_automaton_matcher.sv
